@@ design/iil_pkg.sv @@
// iil_pkg: shared types and constants for the indexed insert/remove list
// used by iil_ctrl, iil_dpath and indexed_insert_remove_list_top
package iil_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  // fixed field widths of the transaction ports
  localparam int OP_W    = 2;
  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int ADDR_W  = $clog2(CAPACITY);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;  // capture the incoming operands
    logic exec;  // apply the captured operation and update the result
  } dp_cmd_t;

endpackage

@@ design/indexed_insert_remove_list_top.sv @@
// Indexed insert/remove list of 16 words of 32 bits. Each input transaction
// (opcode, position, value) yields one result transaction (status, old_value,
// entry_count). An item is captured in the operand register and applied once
// the result register is free; no new item is taken until then, as the
// operand register holds one item while the entry file shifts all words in
// parallel and the result register loads. A new item is accepted while the
// previous result waits on out_stall; it is applied once that result leaves.
// No clearing pass after reset: entries are written before they are read.
// depends on iil_pkg, iil_ctrl and iil_dpath
module indexed_insert_remove_list_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [iil_pkg::OP_W-1:0]    opcode,
  input  logic [iil_pkg::POS_W-1:0]   position,
  input  logic [iil_pkg::VAL_W-1:0]   value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [iil_pkg::STAT_W-1:0]  status,
  output logic [iil_pkg::VAL_W-1:0]   old_value,
  output logic [iil_pkg::CNT_W-1:0]   entry_count
);
  import iil_pkg::*;

  dp_cmd_t cmd;

  iil_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  iil_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .opcode      (opcode),
    .position    (position),
    .value       (value),
    .status      (status),
    .old_value   (old_value),
    .entry_count (entry_count)
  );

  // an accepted transaction holds off input in the cycle after it is accepted
  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while an item was still held");

  // full is only ever reported at capacity
  a_full_at_cap: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> entry_count == CNT_W'(CAPACITY))
    else $error("full status below capacity");

  // count never exceeds capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // a failed operation returns zero for the old word
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> old_value == '0)
    else $error("nonzero old value on error");

endmodule

@@ design/iil_ctrl.sv @@
// iil_ctrl: handshake controller for the indexed insert/remove list
// depends on iil_pkg for the command struct
module iil_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output iil_pkg::dp_cmd_t cmd
);
  import iil_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_LOADED
  } state_t;

  state_t state;

  // operands held until the result register is free
  assign in_stall = (state == S_LOADED);
  assign cmd.load = in_valid && !in_stall;
  assign cmd.exec = (state == S_LOADED) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.load) state <= S_LOADED;
        end
        S_LOADED: begin
          if (cmd.exec) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (cmd.exec) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ design/iil_dpath.sv @@
// iil_dpath: entry register file, count and result registers of the list
// every entry shifts in parallel; depends on iil_pkg
module iil_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  iil_pkg::dp_cmd_t            cmd,
  input  logic [iil_pkg::OP_W-1:0]    opcode,
  input  logic [iil_pkg::POS_W-1:0]   position,
  input  logic [iil_pkg::VAL_W-1:0]   value,
  output logic [iil_pkg::STAT_W-1:0]  status,
  output logic [iil_pkg::VAL_W-1:0]   old_value,
  output logic [iil_pkg::CNT_W-1:0]   entry_count
);
  import iil_pkg::*;

  logic [OP_W-1:0]       op_q;
  logic [POS_W-1:0]      pos_q;
  logic [DATA_WIDTH-1:0] val_q;

  logic [DATA_WIDTH-1:0] entries [CAPACITY];
  logic [DATA_WIDTH-1:0] entries_next [CAPACITY];
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;

  status_t               stat_next;
  logic [DATA_WIDTH-1:0] old_next;
  logic                  do_insert;
  logic                  do_set;
  logic                  do_remove;
  logic                  pos_gt_count;
  logic                  pos_ge_count;
  logic [DATA_WIDTH-1:0] rd_word;

  // compare at the wider of the two widths
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  assign pos_gt_count = CMP_W'(pos_q) >  CMP_W'(count);
  assign pos_ge_count = CMP_W'(pos_q) >= CMP_W'(count);
  assign rd_word      = entries[pos_q[ADDR_W-1:0]];

  always_comb begin
    stat_next  = ST_OK;
    old_next   = '0;
    do_insert  = 1'b0;
    do_set     = 1'b0;
    do_remove  = 1'b0;
    count_next = count;
    case (opcode_t'(op_q))
      OP_INSERT: begin
        if (pos_gt_count) begin
          stat_next = ST_RANGE;
        end else if (count == CNT_W'(CAPACITY)) begin
          stat_next = ST_FULL;
        end else begin
          do_insert  = 1'b1;
          count_next = count + 1'b1;
        end
      end
      OP_SET: begin
        if (pos_ge_count) begin
          stat_next = ST_RANGE;
        end else begin
          do_set   = 1'b1;
          old_next = rd_word;
        end
      end
      OP_REMOVE: begin
        if (pos_ge_count) begin
          stat_next = ST_RANGE;
        end else begin
          do_remove  = 1'b1;
          old_next   = rd_word;
          count_next = count - 1'b1;
        end
      end
      default: ;
    endcase
  end

  // per-entry next value: each slot looks only at its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    localparam logic [CMP_W-1:0] IDX = CMP_W'(i);
    logic at_pos;
    logic above_pos;
    assign at_pos    = CMP_W'(pos_q) == IDX;
    assign above_pos = CMP_W'(pos_q) <  IDX;

    always_comb begin
      entries_next[i] = entries[i];
      if ((do_insert || do_set) && at_pos) begin
        entries_next[i] = val_q;
      end else if (do_insert && above_pos) begin
        entries_next[i] = entries[(i > 0) ? i - 1 : 0];
      end else if (do_remove && (at_pos || above_pos) && (i < CAPACITY - 1)) begin
        entries_next[i] = entries[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= opcode;
      pos_q <= position;
      val_q <= value[DATA_WIDTH-1:0];
    end
    if (cmd.exec) begin
      for (int k = 0; k < CAPACITY; k++) begin
        entries[k] <= entries_next[k];
      end
      status    <= stat_next;
      old_value <= VAL_W'(old_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  assign entry_count = count;

endmodule

@@ bench/indexed_insert_remove_list_top_tb.sv @@
// testbench for indexed_insert_remove_list_top: drives list operations with random idling
// and backpressure, and checks every result against a behavioral list held in the bench
// depends on iil_pkg and the indexed_insert_remove_list_top rtl
module indexed_insert_remove_list_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iil_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES    = 150;

  // operation mix of the random traffic
  localparam int MIX_BALANCED = 0;
  localparam int MIX_FILL     = 1;
  localparam int MIX_DRAIN    = 2;

  typedef struct packed {
    status_t              status;
    logic [VAL_W-1:0]     old_value;
    logic [CNT_W-1:0]     entry_count;
  } list_result_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [OP_W-1:0]    opcode;
  logic [POS_W-1:0]   position;
  logic [VAL_W-1:0]   value;
  logic               out_valid;
  logic               out_stall;
  logic [STAT_W-1:0]  status;
  logic [VAL_W-1:0]   old_value;
  logic [CNT_W-1:0]   entry_count;

  // behavioral copy of the list
  logic [DATA_WIDTH-1:0] list_words [CAPACITY];
  int unsigned           list_len;

  list_result_t expected_results [$];
  int           error_count;
  bit           idle_on;
  bit           hold_request;

  indexed_insert_remove_list_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .position    (position),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .old_value   (old_value),
    .entry_count (entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // applies one operation to the bench list and returns the result it should give
  function automatic list_result_t apply_list_op(input opcode_t op,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic [VAL_W-1:0] val);
    list_result_t r;
    int unsigned  j;
    r.status    = ST_OK;
    r.old_value = '0;
    case (op)
      OP_INSERT: begin
        if (pos > list_len) begin
          r.status = ST_RANGE;
        end else if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (j = list_len; j > pos; j--)
            list_words[ADDR_W'(j)] = list_words[ADDR_W'(j - 1)];
          list_words[pos[ADDR_W-1:0]] = val[DATA_WIDTH-1:0];
          list_len++;
        end
      end
      OP_SET: begin
        if (pos >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          r.old_value                 = list_words[pos[ADDR_W-1:0]];
          list_words[pos[ADDR_W-1:0]] = val[DATA_WIDTH-1:0];
        end
      end
      OP_REMOVE: begin
        if (pos >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          r.old_value = list_words[pos[ADDR_W-1:0]];
          for (j = pos; j + 1 < list_len; j++)
            list_words[ADDR_W'(j)] = list_words[ADDR_W'(j + 1)];
          list_len--;
        end
      end
      default: ;
    endcase
    r.entry_count = list_len[CNT_W-1:0];
    return r;
  endfunction

  task automatic send_list_op(input opcode_t op, input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] val);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 18) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode   = op;
    position = pos;
    value    = val;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(apply_list_op(op, pos, val));
  endtask

  task automatic send_random_op(input int mix);
    int unsigned        roll;
    int unsigned        ins_lim;
    int unsigned        set_lim;
    opcode_t            op;
    logic [POS_W-1:0]   pos;
    logic [VAL_W-1:0]   val;
    case (mix)
      MIX_FILL:  begin ins_lim = 55; set_lim = 75; end
      MIX_DRAIN: begin ins_lim = 20; set_lim = 40; end
      default:   begin ins_lim = 35; set_lim = 60; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < ins_lim) op = OP_INSERT;
    else if (roll < set_lim) op = OP_SET;
    else if (roll < 95) op = OP_REMOVE;
    else op = OP_NONE;
    // mostly near the live range, sometimes anywhere in the field
    if ($urandom_range(0, 99) < 85) pos = POS_W'($urandom_range(0, list_len));
    else pos = POS_W'($urandom_range(0, 31));
    roll = $urandom_range(0, 99);
    if (roll < 5) val = '0;
    else if (roll < 10) val = '1;
    else val = $urandom;
    send_list_op(op, pos, val);
  endtask

  task automatic test_edge_cases();
    send_list_op(OP_REMOVE, 0, 32'h1234_5678);
    send_list_op(OP_SET,    0, 32'h1111_1111);
    send_list_op(OP_INSERT, 1, 32'h2222_2222);
    send_list_op(OP_NONE,   0, 32'h3333_3333);
    send_list_op(OP_INSERT, 0, 32'h0000_0000);
    send_list_op(OP_INSERT, 0, 32'hffff_ffff);
    send_list_op(OP_INSERT, 2, 32'ha5a5_a5a5);   // append at the tail
    send_list_op(OP_INSERT, 1, 32'h5a5a_5a5a);   // middle insert shifts up
    send_list_op(OP_SET,    0, 32'h0000_0001);
    send_list_op(OP_SET,    4, 32'hdead_beef);   // index equal to count
    send_list_op(OP_REMOVE, 4, 32'h0);
    send_list_op(OP_REMOVE, 1, 32'h0);
    send_list_op(OP_REMOVE, 2, 32'h0);
    send_list_op(OP_INSERT, 31, 32'hcafe_f00d);
    send_list_op(OP_INSERT, 16, 32'h0bad_0bad);
    send_list_op(OP_NONE,   31, 32'hffff_ffff);
    send_list_op(OP_REMOVE, 0, 32'h0);
    send_list_op(OP_REMOVE, 0, 32'h0);
  endtask

  task automatic test_full_list();
    while (list_len < CAPACITY)
      send_list_op(OP_INSERT, POS_W'($urandom_range(0, list_len)), $urandom);
    send_list_op(OP_INSERT, 0, 32'h7777_7777);
    send_list_op(OP_INSERT, 16, 32'h8888_8888);
    send_list_op(OP_INSERT, 17, 32'h9999_9999);
    send_list_op(OP_SET,    15, 32'hffff_ffff);
    send_list_op(OP_SET,    16, 32'h0);
    send_list_op(OP_REMOVE, 15, 32'h0);
    send_list_op(OP_REMOVE, 0, 32'h0);
  endtask

  task automatic test_random_traffic(input int n, input int mix);
    repeat (n) send_random_op(mix);
  endtask

  // receiver holds off for a long stretch while items keep coming back to back
  task automatic test_backpressure();
    idle_on      = 1'b0;
    hold_request = 1'b1;
    repeat (60) send_random_op(MIX_BALANCED);
    idle_on = 1'b1;
  endtask

  initial begin : receiver
    int unsigned wait_cycles;
    out_stall = 1'b0;
    wait (!rst);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        wait_cycles  = HOLD_CYCLES;
      end else begin
        wait_cycles = idle_on ? $urandom_range(0, 18) : 0;
      end
      if (wait_cycles > 0) begin
        out_stall = 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    list_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result status %0d old_value %h entry_count %0d",
                 $time, status, old_value, entry_count);
      end else begin
        exp_r = expected_results.pop_front();
        if (status !== exp_r.status || old_value !== exp_r.old_value ||
            entry_count !== exp_r.entry_count) begin
          error_count++;
          $display("%0t: mismatch expected status %0d old_value %h entry_count %0d,",
                   $time, exp_r.status, exp_r.old_value, exp_r.entry_count,
                   " got status %0d old_value %h entry_count %0d",
                   status, old_value, entry_count);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: no transaction for %0d cycles, %0d results outstanding",
             $time, WATCHDOG_LIMIT, expected_results.size());
    $display("indexed_insert_remove_list_top_tb failed");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    opcode       = OP_INSERT;
    position     = '0;
    value        = '0;
    list_len     = 0;
    error_count  = 0;
    idle_on      = 1'b1;
    hold_request = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_edge_cases();
    test_full_list();
    test_random_traffic(150, MIX_FILL);
    test_random_traffic(150, MIX_DRAIN);
    idle_on = 1'b0;
    test_random_traffic(100, MIX_BALANCED);
    idle_on = 1'b1;
    test_backpressure();
    test_random_traffic(120, MIX_FILL);
    test_random_traffic(100, MIX_DRAIN);

    @(negedge clk);
    in_valid = 1'b0;
    wait (expected_results.size() == 0);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("indexed_insert_remove_list_top_tb passed");
    end else begin
      $display("indexed_insert_remove_list_top_tb failed");
    end
    $finish;
  end

endmodule
